@@ rtl/rbst_pkg.sv @@
// Shared widths, types and register codes for the ray box slab test unit.
package rbst_pkg;

    localparam int CW     = 32;                  // coordinate width
    localparam int FB     = 16;                  // fraction bits
    localparam int NW     = CW + FB;             // scaled numerator / quotient width
    localparam int STEP   = 4;                   // quotient bits per divider stage
    localparam int NSTAGE = NW / STEP;           // divider stages
    localparam int LAT    = NSTAGE + 4;          // prep, divider, saturate, reduce, output
    localparam int IDXW   = 3;                   // configuration index width
    localparam logic signed [CW-1:0] EPS = CW'(((2 ** FB) + 5000) / 10000);

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [IDXW-1:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_MAX_X,
        REG_MAX_Y,
        REG_MAX_Z
    } t_reg_idx;

    // One division in flight: partial remainder, numerator bits still to be
    // consumed shifted together with the quotient bits already produced.
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [NW-1:0] nq;
        logic [CW-1:0] dv;
        logic          neg;
    } t_div;

endpackage

@@ rtl/rbst_prep.sv @@
// Per-axis front stage: direction fix-up, slab numerators and divider setup.
module rbst_prep (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbst_pkg::t_coord i_org,
    input  rbst_pkg::t_coord i_dir,
    input  rbst_pkg::t_coord i_lo,
    input  rbst_pkg::t_coord i_hi,
    output rbst_pkg::t_div  o_in,
    output rbst_pkg::t_div  o_out
);

    function automatic rbst_pkg::t_div make_div(
        input rbst_pkg::t_coord a,
        input rbst_pkg::t_coord b,
        input logic [rbst_pkg::CW-1:0] dv,
        input logic neg_d
    );
        logic signed [rbst_pkg::CW:0] diff;
        logic [rbst_pkg::CW:0] mag;
        rbst_pkg::t_div d;
        diff  = {a[rbst_pkg::CW-1], a} - {b[rbst_pkg::CW-1], b};
        mag   = diff[rbst_pkg::CW] ? (~diff + 1'b1) : diff;
        d.rem = '0;
        d.nq  = {mag[rbst_pkg::CW-1:0], {rbst_pkg::FB{1'b0}}};
        d.dv  = dv;
        d.neg = diff[rbst_pkg::CW] ^ neg_d;
        return d;
    endfunction

    rbst_pkg::t_coord dir_fix;
    logic             neg_d;
    logic [rbst_pkg::CW-1:0] dv;
    rbst_pkg::t_div   n_in, n_out, r_in, r_out;

    always_comb begin
        // A zero direction behaves as one LSB in the positive direction.
        dir_fix = (i_dir == '0) ? rbst_pkg::t_coord'(1) : i_dir;
        neg_d   = dir_fix[rbst_pkg::CW-1];
        dv      = neg_d ? (~dir_fix + 1'b1) : dir_fix;
        if (neg_d) begin
            n_in  = make_div(i_hi, i_org, dv, neg_d);
            n_out = make_div(i_lo, i_org, dv, neg_d);
        end else begin
            n_in  = make_div(i_lo, i_org, dv, neg_d);
            n_out = make_div(i_hi, i_org, dv, neg_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in  <= n_in;
            r_out <= n_out;
        end
    end

    assign o_in  = r_in;
    assign o_out = r_out;

endmodule

@@ rtl/rbst_div_stage.sv @@
// One registered stage of the restoring divider, four quotient bits per stage.
module rbst_div_stage (
    input  logic           i_clk,
    input  logic           i_en,
    input  rbst_pkg::t_div i_d,
    output rbst_pkg::t_div o_d
);

    rbst_pkg::t_div n_d, r_d;

    always_comb begin
        logic [rbst_pkg::CW:0] trial;
        logic                  qbit;
        n_d = i_d;
        for (int k = 0; k < rbst_pkg::STEP; k++) begin
            trial = {n_d.rem, n_d.nq[rbst_pkg::NW-1]};
            qbit  = (trial >= {1'b0, n_d.dv});
            if (qbit) begin
                trial = trial - {1'b0, n_d.dv};
            end
            n_d.rem = trial[rbst_pkg::CW-1:0];
            n_d.nq  = {n_d.nq[rbst_pkg::NW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ rtl/rbst_div.sv @@
// Pipelined fixed-point divider lane with signed saturation on the quotient.
module rbst_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  rbst_pkg::t_div   i_d,
    output rbst_pkg::t_coord o_t
);

    localparam logic [rbst_pkg::NW-1:0] POS_LIM = {{(rbst_pkg::FB+1){1'b0}},
                                                   {(rbst_pkg::CW-1){1'b1}}};
    localparam logic [rbst_pkg::NW-1:0] NEG_LIM = POS_LIM + 1'b1;

    rbst_pkg::t_div   w_s [rbst_pkg::NSTAGE+1];
    logic [rbst_pkg::NW-1:0] q, q_neg;
    rbst_pkg::t_coord n_t, r_t;

    assign w_s[0] = i_d;

    for (genvar g = 0; g < rbst_pkg::NSTAGE; g++) begin : g_stage
        rbst_div_stage u_stage (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_s[g]),
            .o_d   (w_s[g+1])
        );
    end

    always_comb begin
        q     = w_s[rbst_pkg::NSTAGE].nq;
        q_neg = (q > NEG_LIM) ? NEG_LIM : q;
        if (w_s[rbst_pkg::NSTAGE].neg) begin
            n_t = ~q_neg[rbst_pkg::CW-1:0] + 1'b1;
        end else begin
            n_t = (q > POS_LIM) ? POS_LIM[rbst_pkg::CW-1:0] : q[rbst_pkg::CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

@@ rtl/rbst_reduce.sv @@
// Largest entry, smallest exit, then the hit decision into the output register.
module rbst_reduce (
    input  logic             i_clk,
    input  logic             i_en,
    input  rbst_pkg::t_coord i_tin  [3],
    input  rbst_pkg::t_coord i_tout [3],
    output logic             o_hit,
    output rbst_pkg::t_coord o_entry,
    output rbst_pkg::t_coord o_exit
);

    rbst_pkg::t_coord n_entry, n_exit, r_entry, r_exit;
    rbst_pkg::t_coord r_o_entry, r_o_exit;
    logic             n_hit, r_hit;

    always_comb begin
        n_entry = i_tin[0];
        n_exit  = i_tout[0];
        for (int k = 1; k < 3; k++) begin
            if (i_tin[k] > n_entry) begin
                n_entry = i_tin[k];
            end
            if (i_tout[k] < n_exit) begin
                n_exit = i_tout[k];
            end
        end
    end

    assign n_hit = !(r_exit < r_entry) && !(r_exit < rbst_pkg::EPS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry   <= n_entry;
            r_exit    <= n_exit;
            r_hit     <= n_hit;
            r_o_entry <= r_entry;
            r_o_exit  <= r_exit;
        end
    end

    assign o_hit   = r_hit;
    assign o_entry = r_o_entry;
    assign o_exit  = r_o_exit;

endmodule

@@ rtl/ray_box_slab_test_unit.sv @@
// Top level of the ray versus axis-aligned box slab test pipeline.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   ray in    i_valid / o_ready      i_origin_x/y/z, i_dir_x/y/z (signed Q16.16)
//   result    o_valid / i_ready      o_hit, o_t_entry, o_t_exit (signed Q16.16)
//   config    i_cfg_we               i_cfg_idx, i_cfg_data (box corners)
//
// Every ray passes through one setup stage, twelve divider stages of four quotient
// bits each (the 48-bit scaled numerator sets this), one saturation stage, one
// min/max stage and the output register. One ray beat can be taken every cycle
// while the output register is not stalled. A single enable moves all stages
// together; it is low only while the output register holds a beat that the
// sink does not take, so a stall freezes the whole pipe without loss.
// Reset clears the valid bits and the box registers to zero.
module ray_box_slab_test_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [31:0]        i_origin_x,
    input  logic signed [31:0]        i_origin_y,
    input  logic signed [31:0]        i_origin_z,
    input  logic signed [31:0]        i_dir_x,
    input  logic signed [31:0]        i_dir_y,
    input  logic signed [31:0]        i_dir_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_hit,
    output logic signed [31:0]        o_t_entry,
    output logic signed [31:0]        o_t_exit,
    input  logic                      i_cfg_we,
    input  logic [rbst_pkg::IDXW-1:0] i_cfg_idx,
    input  logic [31:0]               i_cfg_data
);

    // Box corners; reset leaves a degenerate box at the origin.
    rbst_pkg::t_coord r_box_min [3];
    rbst_pkg::t_coord r_box_max [3];

    // One valid bit per pipeline stage; the last one is the output register.
    logic [rbst_pkg::LAT-1:0] r_vld;
    logic                     en;

    rbst_pkg::t_coord org [3];
    rbst_pkg::t_coord dir [3];
    rbst_pkg::t_div   div_in  [3];
    rbst_pkg::t_div   div_out [3];
    rbst_pkg::t_coord tin  [3];
    rbst_pkg::t_coord tout [3];

    assign en      = !r_vld[rbst_pkg::LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[rbst_pkg::LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[rbst_pkg::LAT-2:0], i_valid};
        end
    end

    // Configuration writes land directly; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box_min[k] <= '0;
                r_box_max[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (rbst_pkg::t_reg_idx'(i_cfg_idx))
                rbst_pkg::REG_MIN_X: r_box_min[0] <= i_cfg_data;
                rbst_pkg::REG_MIN_Y: r_box_min[1] <= i_cfg_data;
                rbst_pkg::REG_MIN_Z: r_box_min[2] <= i_cfg_data;
                rbst_pkg::REG_MAX_X: r_box_max[0] <= i_cfg_data;
                rbst_pkg::REG_MAX_Y: r_box_max[1] <= i_cfg_data;
                rbst_pkg::REG_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    // Each axis gets a setup stage and two divider lanes, one for the entry
    // distance and one for the exit distance.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_prep u_prep (
            .i_clk (i_clk),
            .i_en  (en),
            .i_org (org[a]),
            .i_dir (dir[a]),
            .i_lo  (r_box_min[a]),
            .i_hi  (r_box_max[a]),
            .o_in  (div_in[a]),
            .o_out (div_out[a])
        );

        rbst_div u_div_in (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (div_in[a]),
            .o_t   (tin[a])
        );

        rbst_div u_div_out (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (div_out[a]),
            .o_t   (tout[a])
        );
    end

    rbst_reduce u_reduce (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tin   (tin),
        .i_tout  (tout),
        .o_hit   (o_hit),
        .o_entry (o_t_entry),
        .o_exit  (o_t_exit)
    );

    // A reported hit always has its exit at or beyond its entry.
    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !(o_t_exit < o_t_entry))
        else $error("hit reported with exit before entry");

    // A reported hit always lies at least epsilon ahead of the origin.
    a_hit_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !(o_t_exit < rbst_pkg::EPS))
        else $error("hit reported with exit behind epsilon");

    // While the pipe is frozen no valid bit may move.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ray versus axis-aligned box slab test unit.
module testbench;

    // One ray beat as presented on the input channel.
    typedef struct packed {
        rbst_pkg::t_coord ox, oy, oz;
        rbst_pkg::t_coord dx, dy, dz;
    } t_ray;

    // One expected result beat.
    typedef struct packed {
        logic             hit;
        rbst_pkg::t_coord t_in;
        rbst_pkg::t_coord t_out;
    } t_slab_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    rbst_pkg::t_coord          i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    rbst_pkg::t_coord          i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_hit;
    rbst_pkg::t_coord          o_t_entry, o_t_exit;
    logic                      i_cfg_we = 1'b0;
    logic [rbst_pkg::IDXW-1:0] i_cfg_idx = '0;
    logic [31:0]               i_cfg_data = '0;

    ray_box_slab_test_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // Rays waiting for the driver, and results the monitor still expects.
    t_ray             ray_queue[$];
    t_slab_result     result_queue[$];
    rbst_pkg::t_coord box_lo[3], box_hi[3];
    int               mismatches = 0;
    int               rays_sent = 0;
    bit               quiet_tail = 1'b0;
    bit               monitor_done = 1'b0;

    // Handshake seen at the last rising edge, so the driver knows whether its beat
    // went in.
    logic o_ready_q = 1'b0;
    always @(posedge i_clk) o_ready_q <= o_ready;

    function automatic void queue_ray(t_ray r);
        ray_queue = {ray_queue, r};
    endfunction

    // Fixed-point (a - b) / d on magnitudes, truncated toward zero and saturated
    // to the signed 32-bit range. A zero divisor never reaches here.
    function automatic rbst_pkg::t_coord slab_quotient(rbst_pkg::t_coord a,
                                                       rbst_pkg::t_coord b,
                                                       rbst_pkg::t_coord d);
        logic signed [33:0] num;
        logic        [33:0] mag;
        logic        [32:0] dmag;
        logic        [63:0] q;
        logic               neg;
        num  = 34'(a) - 34'(b);
        neg  = (num < 0) != (d < 0);
        mag  = num < 0 ? 34'(-num) : 34'(num);
        dmag = d < 0 ? 33'(-34'(d)) : 33'(d);
        q    = {mag, 16'h0} / 64'(dmag);
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return rbst_pkg::t_coord'(-q);
        end
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        return rbst_pkg::t_coord'(q);
    endfunction

    // Slab test of one ray against the current box.
    function automatic t_slab_result predict_slab(t_ray r);
        rbst_pkg::t_coord org[3], dir[3], near_t, far_t, t_in, t_out;
        t_slab_result res;
        org = '{r.ox, r.oy, r.oz};
        dir = '{r.dx, r.dy, r.dz};
        for (int k = 0; k < 3; k++) begin
            if (dir[k] == 0) dir[k] = 1;
            if (dir[k] > 0) begin
                near_t = slab_quotient(box_lo[k], org[k], dir[k]);
                far_t  = slab_quotient(box_hi[k], org[k], dir[k]);
            end else begin
                near_t = slab_quotient(box_hi[k], org[k], dir[k]);
                far_t  = slab_quotient(box_lo[k], org[k], dir[k]);
            end
            if (k == 0 || near_t > t_in) t_in = near_t;
            if (k == 0 || far_t < t_out) t_out = far_t;
        end
        res.hit   = (t_out >= t_in) && (t_out >= rbst_pkg::EPS);
        res.t_in  = t_in;
        res.t_out = t_out;
        return res;
    endfunction

    // Random coordinate: mostly modest values in a few units, sometimes full range
    // or an extreme, so every bit toggles and saturation gets exercised.
    function automatic rbst_pkg::t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return rbst_pkg::t_coord'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            2: return rbst_pkg::t_coord'($signed($urandom_range(0, 16)) - 8);
            default: return rbst_pkg::t_coord'($signed($urandom_range(0, 32'h0014_0000))
                                               - 32'sh000a_0000);
        endcase
    endfunction

    function automatic rbst_pkg::t_coord rand_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return rbst_pkg::t_coord'($urandom);
            2: return rbst_pkg::t_coord'($signed($urandom_range(0, 6)) - 3);
            default: return rbst_pkg::t_coord'($signed($urandom_range(0, 32'h0002_0000))
                                               - 32'sh0001_0000);
        endcase
    endfunction

    // Driver: one beat held stable until accepted, with random idle bursts.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_q) begin
                rays_sent <= rays_sent + 1;
            end
            if (!(i_valid && !o_ready_q)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (ray_queue.size() > 0 && !(i_valid && o_ready_q &&
                                                      !quiet_tail &&
                                                      $urandom_range(0, 9) == 0)) begin
                    t_ray r;
                    r = ray_queue.pop_front();
                    {i_origin_x, i_origin_y, i_origin_z} <= {r.ox, r.oy, r.oz};
                    {i_dir_x, i_dir_y, i_dir_z}          <= {r.dx, r.dy, r.dz};
                    i_valid <= 1'b1;
                    result_queue = {result_queue, predict_slab(r)};
                end else begin
                    i_valid <= 1'b0;
                    if (!quiet_tail && ray_queue.size() > 0)
                        send_gap <= $urandom_range(1, 13);
                end
            end
        end
    end

    // Sink stall bursts.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (quiet_tail || !i_rst_n) begin
            i_ready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 13);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (result_queue.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0b entry=%0d exit=%0d",
                             o_hit, o_t_entry, o_t_exit);
            end else begin
                t_slab_result want;
                want = result_queue.pop_front();
                if (want.hit !== o_hit || want.t_in !== o_t_entry ||
                    want.t_out !== o_t_exit) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch: expected hit=%0b entry=%0d exit=%0d, ",
                                  "got hit=%0b entry=%0d exit=%0d"},
                                 want.hit, want.t_in, want.t_out,
                                 o_hit, o_t_entry, o_t_exit);
                end
            end
        end
    end

    // Register write on the falling edge; it lands at the next rising edge.
    task automatic write_box(rbst_pkg::t_reg_idx idx, rbst_pkg::t_coord value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx <= rbst_pkg::REG_MIN_Z) box_lo[idx] = value;
        else                            box_hi[idx - rbst_pkg::REG_MAX_X] = value;
    endtask

    task automatic load_box(rbst_pkg::t_coord lx, rbst_pkg::t_coord ly,
                            rbst_pkg::t_coord lz, rbst_pkg::t_coord hx,
                            rbst_pkg::t_coord hy, rbst_pkg::t_coord hz);
        write_box(rbst_pkg::REG_MIN_X, lx);
        write_box(rbst_pkg::REG_MIN_Y, ly);
        write_box(rbst_pkg::REG_MIN_Z, lz);
        write_box(rbst_pkg::REG_MAX_X, hx);
        write_box(rbst_pkg::REG_MAX_Y, hy);
        write_box(rbst_pkg::REG_MAX_Z, hz);
    endtask

    // Block until every queued ray went in and every result came back.
    task automatic drain();
        while (ray_queue.size() > 0 || i_valid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (rbst_pkg::LAT + 4) @(posedge i_clk);
    endtask

    function automatic t_ray make_ray(rbst_pkg::t_coord ox, rbst_pkg::t_coord oy,
                                      rbst_pkg::t_coord oz, rbst_pkg::t_coord dx,
                                      rbst_pkg::t_coord dy, rbst_pkg::t_coord dz);
        t_ray r;
        r = '{ox, oy, oz, dx, dy, dz};
        return r;
    endfunction

    localparam rbst_pkg::t_coord ONE = 32'sh0001_0000;
    localparam rbst_pkg::t_coord MAXC = 32'sh7fff_ffff;
    localparam rbst_pkg::t_coord MINC = 32'sh8000_0000;

    initial begin
        t_ray r;
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = '0;
            box_hi[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rays against the reset box (all corners at zero).
        queue_ray(make_ray('0, '0, '0, '0, '0, '0));
        queue_ray(make_ray(-ONE, '0, '0, ONE, '0, '0));
        drain();

        // Unit box: hits from each axis, misses, zero and negative directions,
        // a ray starting inside, one just behind the origin and extremes.
        load_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        queue_ray(make_ray(-4*ONE, '0, '0, ONE, '0, '0));
        queue_ray(make_ray('0, 4*ONE, '0, '0, -ONE, '0));
        queue_ray(make_ray('0, '0, -4*ONE, '0, '0, ONE));
        queue_ray(make_ray('0, '0, '0, ONE, ONE, ONE));
        queue_ray(make_ray(-4*ONE, 3*ONE, '0, ONE, '0, '0));
        queue_ray(make_ray(4*ONE, '0, '0, ONE, '0, '0));
        queue_ray(make_ray(ONE + 3, '0, '0, -1, '0, '0));
        queue_ray(make_ray(ONE - 3, '0, '0, -ONE, '0, '0));
        queue_ray(make_ray(MAXC, MINC, MAXC, MINC, MAXC, MINC));
        queue_ray(make_ray(MINC, MINC, MINC, 1, 1, 1));
        queue_ray(make_ray(MAXC, MAXC, MAXC, -1, -1, -1));
        queue_ray(make_ray(-2*ONE, -2*ONE, -2*ONE, MAXC, MAXC, MAXC));
        queue_ray(make_ray('0, '0, '0, MINC, '0, '1));
        drain();

        // Extreme and inverted boxes.
        load_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
        queue_ray(make_ray('0, '0, '0, ONE, -ONE, '0));
        queue_ray(make_ray(MAXC, MINC, '0, MINC, MAXC, 1));
        drain();
        load_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
        queue_ray(make_ray(-4*ONE, '0, '0, ONE, '0, '0));
        queue_ray(make_ray('0, '0, '0, '0, '0, '0));
        drain();

        // Random phases, each with its own box; the last one runs without idling.
        for (int phase = 0; phase < 6; phase++) begin
            rbst_pkg::t_coord a, b;
            for (int k = 0; k < 6; k++) begin
                a = rand_coord();
                write_box(rbst_pkg::t_reg_idx'(k), a);
            end
            // Most boxes well formed so that a fair share of rays hit.
            if (phase < 4) begin
                for (int k = 0; k < 3; k++) begin
                    a = box_lo[k];
                    b = box_hi[k];
                    if (a > b) begin
                        write_box(rbst_pkg::t_reg_idx'(k), b);
                        write_box(rbst_pkg::t_reg_idx'(k + 3), a);
                    end
                end
            end
            if (phase == 5) quiet_tail = 1'b1;
            for (int n = 0; n < 150; n++) begin
                r = make_ray(rand_coord(), rand_coord(), rand_coord(),
                             rand_dir(), rand_dir(), rand_dir());
                // Aim about half the rays from their origin toward the box center.
                if ($urandom_range(0, 1)) begin
                    r.dx = rbst_pkg::t_coord'((64'(box_lo[0]) + 64'(box_hi[0])) / 2
                                              - 64'(r.ox)) >>> 8;
                    r.dy = rbst_pkg::t_coord'((64'(box_lo[1]) + 64'(box_hi[1])) / 2
                                              - 64'(r.oy)) >>> 8;
                    r.dz = rbst_pkg::t_coord'((64'(box_lo[2]) + 64'(box_hi[2])) / 2
                                              - 64'(r.oz)) >>> 8;
                end
                queue_ray(r);
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS ray_box_slab_test_unit");
        else
            $display("FAIL ray_box_slab_test_unit");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL ray_box_slab_test_unit");
        $finish;
    end

endmodule
